@@ hw/rtl/mod_order_scalar_alu_unit_macros.svh @@
// Assertion macros for the order scalar ALU checker.
// No dependencies; included by the checker file only.
`ifndef MOD_ORDER_SCALAR_ALU_UNIT_MACROS_SVH
`define MOD_ORDER_SCALAR_ALU_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define MOSAU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("order scalar ALU check failed");

// Check that cons holds in the cycle after ante.
`define MOSAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("order scalar ALU check failed");

`endif

@@ hw/rtl/osa_pkg.sv @@
// Shared types and constants for the order scalar ALU.
// No dependencies; imported by every RTL module of the block.
package osa_pkg;

    localparam int DW = 32;     // digit width of one multiplier
    localparam int OW = 256;    // operand width
    localparam int XW = 320;    // multiplicand width in the cell chain
    localparam int YW = 256;    // multiplier width in the cell chain
    localparam int HW = 320;    // upper accumulator width
    localparam int LW = 256;    // shifted-out lower product bits
    localparam int PW = 512;    // saved full product
    localparam int RW = 320;    // width of the Barrett remainder

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_RED = 2'd3
    } osa_op_t;

    typedef enum logic [2:0] {
        STEP_Q1,
        STEP_QSUM,
        STEP_QHAT,
        STEP_RPART,
        STEP_RSUM
    } osa_step_t;

    // Group order n
    localparam logic [OW-1:0] ORDER_N =
        256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;
    localparam logic [RW-1:0] ORDER_N_W = RW'(ORDER_N);
    // mu = 2^256 + 2^128 + MU_LO
    localparam logic [127:0] MU_LO = 128'h4551231950B75FC4402DA1732FC9BEC0;
    // 2^256 - n = 2^128 + C_LO
    localparam logic [127:0] C_LO = 128'h4551231950B75FC4402DA1732FC9BEBF;

    // Payload carried from cell to cell
    typedef struct packed {
        osa_op_t         op;
        logic [OW-1:0]   fast;
        logic [XW-1:0]   x;
        logic [YW-1:0]   y;
        logic [HW-1:0]   hi;
        logic [LW-1:0]   lo;
        logic [PW-1:0]   pr;
    } osa_stage_t;

endpackage

@@ hw/rtl/mod_order_scalar_alu_unit.sv @@
// Order scalar ALU, top level: pipeline of cells and the output skid buffer.
// Depends on osa_pkg, osa_front, osa_mac_cell, osa_glue and osa_red_cell.
//
// Computes add, subtract, multiply (Barrett) or reduce modulo the secp256k1
// group order and accepts one transaction every cycle while s_tready is high.
// The row holds 26 pipeline stages: two input stages, eight 32-bit digit cells
// for the 512-bit product, four cells for q1 * mu, four cells for qhat *
// (2^256 - n), five Barrett glue stages and three conditional subtract cells.
// The edge that moves a result out of the last stage loads it into the output
// register, or into the skid buffer while the output register holds a stalled result.
// An output register and a one-entry skid buffer keep s_tready high while a
// single result waits on m_tready.
module mod_order_scalar_alu_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func[1:0], a_limb0..a_limb3, b_limb0..b_limb3, zero pad [519:514]
    input  logic [519:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // r_limb0, r_limb1, r_limb2, r_limb3
    output logic [255:0] m_tdata
);
    import osa_pkg::*;

    localparam int NSTG = 26;

    osa_stage_t     fr;
    osa_stage_t     ma [9];
    osa_stage_t     g1;
    osa_stage_t     mb [5];
    osa_stage_t     g2;
    osa_stage_t     g3;
    osa_stage_t     mc [5];
    osa_stage_t     g4;
    osa_stage_t     g5;
    osa_stage_t     rc [4];
    logic           en;
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [OW-1:0]  res;
    logic           push;
    logic           m_tvalid_reg;
    logic [OW-1:0]  m_data_reg;
    logic           skid_vld_reg;
    logic [OW-1:0]  skid_data_reg;

    // Advance the whole row while the skid buffer is empty
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    osa_front u_front (
        .aclk (aclk),
        .en   (en),
        .func (osa_op_t'(s_tdata[1:0])),
        .a    (s_tdata[257:2]),
        .b    (s_tdata[513:258]),
        .q    (fr)
    );

    // Product chain a * b
    assign ma[0] = fr;
    for (genvar i = 0; i < 8; i++) begin : g_ma
        osa_mac_cell u_cell (.aclk(aclk), .en(en), .d(ma[i]), .q(ma[i+1]));
    end

    osa_glue u_g1 (.aclk(aclk), .en(en), .step(STEP_Q1), .d(ma[8]), .q(g1));

    // Chain q1 * mu_lo
    assign mb[0] = g1;
    for (genvar i = 0; i < 4; i++) begin : g_mb
        osa_mac_cell u_cell (.aclk(aclk), .en(en), .d(mb[i]), .q(mb[i+1]));
    end

    osa_glue u_g2 (.aclk(aclk), .en(en), .step(STEP_QSUM), .d(mb[4]), .q(g2));
    osa_glue u_g3 (.aclk(aclk), .en(en), .step(STEP_QHAT), .d(g2), .q(g3));

    // Chain qhat * C_LO
    assign mc[0] = g3;
    for (genvar i = 0; i < 4; i++) begin : g_mc
        osa_mac_cell u_cell (.aclk(aclk), .en(en), .d(mc[i]), .q(mc[i+1]));
    end

    osa_glue u_g4 (.aclk(aclk), .en(en), .step(STEP_RPART), .d(mc[4]), .q(g4));
    osa_glue u_g5 (.aclk(aclk), .en(en), .step(STEP_RSUM), .d(g4), .q(g5));

    // Final conditional subtracts
    assign rc[0] = g5;
    for (genvar i = 0; i < 3; i++) begin : g_rc
        osa_red_cell u_cell (.aclk(aclk), .en(en), .d(rc[i]), .q(rc[i+1]));
    end

    // Pick the multiply remainder or the fast-path result
    assign res  = (rc[3].op == OP_MUL) ? rc[3].pr[OW-1:0] : rc[3].fast;
    assign push = en && vld_reg[NSTG-1];

    assign vld_next = {vld_reg[NSTG-2:0], s_tvalid && s_tready};

    // Track occupancy of the row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // Output register and skid buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            if (skid_vld_reg) begin
                m_tvalid_reg <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                m_tvalid_reg <= push;
            end
        end else if (push) begin
            skid_vld_reg <= 1'b1;
        end
    end

    // Move payload alongside the valid flags
    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || m_tready) begin
            if (skid_vld_reg) begin
                m_data_reg <= skid_data_reg;
            end else if (push) begin
                m_data_reg <= res;
            end
        end else if (push) begin
            skid_data_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
endmodule

@@ hw/rtl/osa_mac_cell.sv @@
// One multiply-accumulate cell: folds one 32-bit digit of y into the product.
// Depends on osa_pkg.
module osa_mac_cell (
    input  logic                aclk,
    input  logic                en,
    input  osa_pkg::osa_stage_t d,
    output osa_pkg::osa_stage_t q
);
    import osa_pkg::*;

    localparam int NDIG = XW / DW;

    logic [2*DW-1:0]    pp [NDIG];
    logic [XW-1:0]      ev;
    logic [XW-1:0]      od;
    logic [HW+DW-1:0]   t;
    osa_stage_t         q_next;
    osa_stage_t         q_reg;

    // Form x times the low digit of y from 32x32 partial products
    always_comb begin
        for (int j = 0; j < NDIG; j++) begin
            pp[j] = (2*DW)'(d.x[j*DW +: DW]) * (2*DW)'(d.y[DW-1:0]);
        end
        for (int k = 0; k < NDIG/2; k++) begin
            ev[k*2*DW +: 2*DW] = pp[2*k];
            od[k*2*DW +: 2*DW] = pp[2*k+1];
        end
        t = (HW+DW)'(d.hi) + (HW+DW)'(ev) + {od, {DW{1'b0}}};
    end

    // Shift the finished digit out into lo and advance y
    always_comb begin
        q_next    = d;
        q_next.hi = t[HW+DW-1:DW];
        q_next.lo = {t[DW-1:0], d.lo[LW-1:DW]};
        q_next.y  = {{DW{1'b0}}, d.y[YW-1:DW]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;
endmodule

@@ hw/rtl/osa_red_cell.sv @@
// Conditional subtract cell: takes n off the remainder when it is at least n.
// Depends on osa_pkg.
module osa_red_cell (
    input  logic                aclk,
    input  logic                en,
    input  osa_pkg::osa_stage_t d,
    output osa_pkg::osa_stage_t q
);
    import osa_pkg::*;

    logic [RW:0]  diff;
    osa_stage_t   q_next;
    osa_stage_t   q_reg;

    // Subtract n and keep the difference when no borrow
    always_comb begin
        diff   = {1'b0, d.pr[RW-1:0]} - {1'b0, ORDER_N_W};
        q_next = d;
        if (!diff[RW]) begin
            q_next.pr[RW-1:0] = diff[RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;
endmodule

@@ hw/rtl/osa_front.sv @@
// Input stages: register the operands, finish add, subtract and reduce,
// and load the product chain. Depends on osa_pkg.
module osa_front (
    input  logic                aclk,
    input  logic                en,
    input  osa_pkg::osa_op_t    func,
    input  logic [255:0]        a,
    input  logic [255:0]        b,
    output osa_pkg::osa_stage_t q
);
    import osa_pkg::*;

    typedef struct packed {
        osa_op_t        op;
        logic [OW-1:0]  a;
        logic [OW-1:0]  b;
        logic [OW-1:0]  v;
        logic           flag;
    } osa_front_t;

    logic [OW-1:0]  bb;
    logic [OW:0]    sum;
    osa_front_t     f_next;
    osa_front_t     f_reg;
    logic [OW:0]    t_sub;
    logic [OW-1:0]  t_add;
    osa_stage_t     q_next;
    osa_stage_t     q_reg;

    // First step: one shared adder gives a+b, a-b or a
    always_comb begin
        unique case (func)
            OP_SUB:  bb = ~b;
            OP_RED:  bb = '0;
            default: bb = b;
        endcase
        sum         = {1'b0, a} + {1'b0, bb} + (OW+1)'(func == OP_SUB);
        f_next.op   = func;
        f_next.a    = a;
        f_next.b    = b;
        f_next.v    = sum[OW-1:0];
        f_next.flag = (func == OP_SUB) ? ~sum[OW] : sum[OW];
    end

    // Second step: one correction by n, and load the product chain
    always_comb begin
        t_sub       = {1'b0, f_reg.v} - {1'b0, ORDER_N};
        t_add       = f_reg.v + ORDER_N;
        q_next      = '0;
        q_next.op   = f_reg.op;
        q_next.x    = XW'(f_reg.a);
        q_next.y    = YW'(f_reg.b);
        unique case (f_reg.op)
            OP_ADD:  q_next.fast = (f_reg.flag || !t_sub[OW]) ? t_sub[OW-1:0] : f_reg.v;
            OP_SUB:  q_next.fast = f_reg.flag ? t_add : f_reg.v;
            OP_RED:  q_next.fast = !t_sub[OW] ? t_sub[OW-1:0] : f_reg.v;
            default: q_next.fast = f_reg.v;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_reg <= f_next;
            q_reg <= q_next;
        end
    end

    assign q = q_reg;
endmodule

@@ hw/rtl/osa_glue.sv @@
// Barrett glue stage between the cell chains; step selects which one.
// Depends on osa_pkg.
module osa_glue (
    input  logic                aclk,
    input  logic                en,
    input  osa_pkg::osa_step_t  step,
    input  osa_pkg::osa_stage_t d,
    output osa_pkg::osa_stage_t q
);
    import osa_pkg::*;

    logic [RW-1:0]  qc;
    osa_stage_t     q_next;
    osa_stage_t     q_reg;

    always_comb begin
        qc     = {d.hi[RW-129:0], d.lo[LW-1:128]};
        q_next = d;
        unique case (step)
            // Save the product; multiply its upper half q1 by the low part of mu
            STEP_Q1: begin
                q_next.pr = {d.hi[OW-1:0], d.lo};
                q_next.x  = XW'(d.hi[OW-1:0]);
                q_next.y  = YW'(MU_LO);
                q_next.hi = '0;
                q_next.lo = '0;
            end
            // Add q1 to the upper part of q1 * mu_lo
            STEP_QSUM: begin
                q_next.hi = HW'({1'b0, d.pr[PW-1:OW]} + {1'b0, d.hi[OW-1:0]});
            end
            // Quotient estimate; multiply it by the low part of 2^256 - n
            STEP_QHAT: begin
                q_next.x  = XW'({2'b0, d.pr[PW-1:OW]} + (OW+2)'(d.hi[OW:128]));
                q_next.y  = YW'(C_LO);
                q_next.hi = '0;
                q_next.lo = '0;
            end
            // Add qhat * C_LO to the product; form qhat*2^128 - qhat*2^256
            STEP_RPART: begin
                q_next.pr[RW-1:0] = d.pr[RW-1:0] + qc;
                q_next.hi         = HW'((d.x << 128) - (d.x << 256));
            end
            // Remainder before the final subtracts
            STEP_RSUM: begin
                q_next.pr[RW-1:0] = d.pr[RW-1:0] + RW'(d.hi);
            end
            default: begin
                q_next = d;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;
endmodule

@@ hw/rtl/osa_checker.sv @@
// Port-level checks for the order scalar ALU, bound to the top level.
// Depends on mod_order_scalar_alu_unit_macros.svh.
`include "mod_order_scalar_alu_unit_macros.svh"

module osa_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [255:0] m_tdata
);
    // A stalled result holds
    `MOSAU_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // With no result waiting the skid buffer must be empty
    `MOSAU_ASSERT_SAME(a_empty_ready, aclk, aresetn, !m_tvalid, s_tready)

    // A taken result drains a full skid buffer at once
    `MOSAU_ASSERT_NEXT(a_drain, aclk, aresetn, m_tvalid && m_tready && !s_tready, s_tready)

    // The first cycle after reset shows no result
    `MOSAU_ASSERT_NEXT(a_reset, aclk, 1'b1, !aresetn, !m_tvalid)
endmodule

bind mod_order_scalar_alu_unit osa_checker u_osa_checker (.*);
